// ===== rtl/core/psdc_pkg.sv =====
// ----------------------------------------------------------------------------
// psdc_pkg
// Types, constants and register codes shared by the segment drive command
// pipeline.
// ----------------------------------------------------------------------------
package psdc_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 16;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_INDEX_W = 3;

   localparam logic [15:0] DIST_TOLERANCE   = 16'd1311;
   localparam logic [15:0] YAW_TOLERANCE    = 16'd364;
   localparam logic [15:0] YAW_DEADZONE     = 16'd182;
   localparam logic [14:0] TURN_RATE_FLOOR  = 15'd410;
   localparam logic [17:0] PI_Q16           = 18'd205887;
   localparam logic [50:0] ROUND_HALF       = 51'd1 << 26;

   localparam logic [14:0] RST_TRAVEL_SPEED       = 15'd2048;
   localparam logic [30:0] RST_SLOW_DISTANCE      = 31'd19661;
   localparam logic [14:0] RST_CREEP_FLOOR        = 15'd410;
   localparam logic [15:0] RST_HEADING_GAIN       = 16'd512;
   localparam logic [14:0] RST_MAX_ANGULAR_RATE   = 15'd6144;
   localparam logic [14:0] RST_TURN_RATE_NOMINAL  = 15'd4096;
   localparam logic [14:0] RST_SLOW_ANGLE         = 15'd5461;
   localparam logic [15:0] RST_TURN_FORWARD_SPEED = 16'd1229;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_TRAVEL_SPEED,
      REG_SLOW_DISTANCE,
      REG_CREEP_FLOOR,
      REG_HEADING_GAIN,
      REG_MAX_ANGULAR_RATE,
      REG_TURN_RATE_NOMINAL,
      REG_SLOW_ANGLE,
      REG_TURN_FORWARD_SPEED
   } psdc_reg_type;

   typedef enum logic [1:0] {
      PROG_FULL,
      PROG_ZERO,
      PROG_DIV
   } psdc_prog_type;

   typedef struct packed {
      logic               segment_is_turn;
      logic signed [31:0] segment_distance;
      logic signed [15:0] segment_turn_angle;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [15:0] start_yaw;
      logic signed [31:0] current_x;
      logic signed [31:0] current_y;
      logic signed [15:0] current_yaw;
   } psdc_req_type;

   typedef struct packed {
      logic signed [15:0] linear_command;
      logic signed [15:0] angular_command;
      logic        [16:0] progress_fraction;
      logic               segment_done;
   } psdc_rsp_type;

   typedef struct packed {
      logic        [14:0] travel_speed;
      logic        [30:0] slow_distance;
      logic        [14:0] creep_floor;
      logic        [15:0] heading_gain;
      logic        [14:0] max_angular_rate;
      logic        [14:0] turn_rate_nominal;
      logic        [14:0] slow_angle;
      logic signed [15:0] turn_forward_speed;
   } psdc_cfg_type;

   // carried from the front end through the square root
   typedef struct packed {
      logic          is_turn;
      logic          dist_neg;
      logic [31:0]   target;
      logic          sq_ovf;
      logic [15:0]   ang_straight;
      logic          t_done;
      logic          t_slow;
      logic          t_rem_neg;
      psdc_prog_type t_prog;
      logic [15:0]   t_ad;
      logic [15:0]   t_at;
      logic [15:0]   t_arem;
   } psdc_side_type;

   // carried through the dividers to the output stage
   typedef struct packed {
      logic          is_turn;
      logic          done;
      psdc_prog_type prog;
      logic          slow;
      logic          neg;
      logic [15:0]   ang_straight;
   } psdc_tail_type;

endpackage

// ===== rtl/core/psdc_front.sv =====
// ----------------------------------------------------------------------------
// psdc_front
// Operand prep, squares and heading correction: four register stages ahead
// of the square root.
// ----------------------------------------------------------------------------
module psdc_front
   import psdc_pkg::*;
#(
   parameter logic [15:0] YAW_TOL  = YAW_TOLERANCE,
   parameter logic [15:0] DEADZONE = YAW_DEADZONE
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_in,
   input  psdc_req_type  req,
   input  psdc_cfg_type  cfg,
   output logic          valid_out,
   output logic [63:0]   sq_val,
   output psdc_side_type side_out
);

   // stage 1
   logic          v1_ff;
   psdc_side_type side1_ff, side1_in;
   logic [31:0]   ax_ff, ax_in, ay_ff, ay_in;
   logic [15:0]   aed_ff, aed_in;
   logic          eneg1_ff;
   // stage 2
   logic          v2_ff;
   psdc_side_type side2_ff;
   logic [63:0]   sx_ff, sy_ff;
   logic [31:0]   gprod_ff;
   logic          eneg2_ff;
   // stage 3
   logic          v3_ff;
   psdc_side_type side3_ff, side3_in;
   logic [63:0]   sum_ff;
   logic [49:0]   aprod_ff;
   logic          eneg3_ff;
   // stage 4
   logic          v4_ff;
   psdc_side_type side4_ff, side4_in;
   logic [63:0]   sq_ff;

   logic [32:0] dx, dy, adx, ady, dist_ext, dist_abs;
   logic [15:0] e, ae, delta, ad, at;
   logic [16:0] trem, tarem;
   logic [64:0] sum_in;
   logic [50:0] mag_sum;
   logic [23:0] mag;
   logic [14:0] mag_clamp;

   always_comb begin
      dx  = {req.current_x[31], req.current_x} - {req.start_x[31], req.start_x};
      dy  = {req.current_y[31], req.current_y} - {req.start_y[31], req.start_y};
      adx = dx[32] ? (33'd0 - dx) : dx;
      ady = dy[32] ? (33'd0 - dy) : dy;
      ax_in = adx[31:0];
      ay_in = ady[31:0];
      dist_ext = {req.segment_distance[31], req.segment_distance};
      dist_abs = dist_ext[32] ? (33'd0 - dist_ext) : dist_ext;

      e   = req.start_yaw - req.current_yaw;
      ae  = e[15] ? (16'd0 - e) : e;
      aed_in = (ae <= DEADZONE) ? 16'd0 : (ae - DEADZONE);

      delta = req.current_yaw - req.start_yaw;
      trem  = {req.segment_turn_angle[15], req.segment_turn_angle} - {delta[15], delta};
      tarem = trem[16] ? (17'd0 - trem) : trem;
      ad = delta[15] ? (16'd0 - delta) : delta;
      at = req.segment_turn_angle[15] ? (16'd0 - req.segment_turn_angle)
                                      : req.segment_turn_angle;

      side1_in = '0;
      side1_in.is_turn   = req.segment_is_turn;
      side1_in.dist_neg  = req.segment_distance[31];
      side1_in.target    = dist_abs[31:0];
      side1_in.t_done    = tarem[15:0] <= YAW_TOL;
      side1_in.t_slow    = (cfg.slow_angle != 15'd0) && (tarem < {2'b00, cfg.slow_angle});
      side1_in.t_rem_neg = trem[16];
      side1_in.t_ad      = ad;
      side1_in.t_at      = at;
      side1_in.t_arem    = tarem[15:0];
      if (req.segment_turn_angle == 16'sd0) begin
         side1_in.t_prog = PROG_FULL;
      end else if ((delta[15] != req.segment_turn_angle[15]) && (delta != 16'd0)) begin
         side1_in.t_prog = PROG_ZERO;
      end else if (ad >= at) begin
         side1_in.t_prog = PROG_FULL;
      end else begin
         side1_in.t_prog = PROG_DIV;
      end
   end

   always_comb begin
      sum_in    = {1'b0, sx_ff} + {1'b0, sy_ff};
      side3_in  = side2_ff;
      side3_in.sq_ovf = sum_in[64];
      mag_sum   = {1'b0, aprod_ff} + ROUND_HALF;
      mag       = mag_sum[50:27];
      mag_clamp = (mag > {9'd0, cfg.max_angular_rate}) ? cfg.max_angular_rate : mag[14:0];
      side4_in  = side3_ff;
      side4_in.ang_straight = eneg3_ff ? (16'd0 - {1'b0, mag_clamp}) : {1'b0, mag_clamp};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= valid_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         ax_ff    <= ax_in;
         ay_ff    <= ay_in;
         aed_ff   <= aed_in;
         eneg1_ff <= e[15];

         side2_ff <= side1_ff;
         sx_ff    <= ax_ff * ax_ff;
         sy_ff    <= ay_ff * ay_ff;
         gprod_ff <= cfg.heading_gain * aed_ff;
         eneg2_ff <= eneg1_ff;

         side3_ff <= side3_in;
         sum_ff   <= sum_in[63:0];
         aprod_ff <= gprod_ff * PI_Q16;
         eneg3_ff <= eneg2_ff;

         side4_ff <= side4_in;
         sq_ff    <= sum_ff;
      end
   end

   assign valid_out = v4_ff;
   assign sq_val    = sq_ff;
   assign side_out  = side4_ff;

endmodule

// ===== rtl/core/psdc_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// psdc_sqrt_pipe
// Integer square root of a 64-bit word, one result bit per register stage.
// ----------------------------------------------------------------------------
module psdc_sqrt_pipe
   import psdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_in,
   input  logic [63:0]   val_in,
   input  psdc_side_type side_in,
   output logic          valid_out,
   output logic [31:0]   root,
   output psdc_side_type side_out
);

   logic          valid_ff [SQRT_STEPS];
   logic [63:0]   v_ff     [SQRT_STEPS];
   logic [63:0]   r_ff     [SQRT_STEPS];
   psdc_side_type side_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic          valid_i;
      logic [63:0]   v_i, r_i, trial, v_in, r_in;
      psdc_side_type side_i;

      if (k == 0) begin : g_first
         assign valid_i = valid_in;
         assign v_i     = val_in;
         assign r_i     = '0;
         assign side_i  = side_in;
      end else begin : g_next
         assign valid_i = valid_ff[k-1];
         assign v_i     = v_ff[k-1];
         assign r_i     = r_ff[k-1];
         assign side_i  = side_ff[k-1];
      end

      always_comb begin
         trial = r_i + BIT;
         if (v_i >= trial) begin
            v_in = v_i - trial;
            r_in = (r_i >> 1) + BIT;
         end else begin
            v_in = v_i;
            r_in = r_i >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]    <= v_in;
            r_ff[k]    <= r_in;
            side_ff[k] <= side_i;
         end
      end
   end

   assign valid_out = valid_ff[SQRT_STEPS-1];
   assign root      = r_ff[SQRT_STEPS-1][31:0];
   assign side_out  = side_ff[SQRT_STEPS-1];

endmodule

// ===== rtl/core/psdc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// psdc_div_pipe
// Remaining error and slowdown setup, then two restoring dividers side by
// side: progress fraction and slowdown speed or rate, one bit per stage.
// ----------------------------------------------------------------------------
module psdc_div_pipe
   import psdc_pkg::*;
#(
   parameter logic [15:0] DIST_TOL = DIST_TOLERANCE
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          valid_in,
   input  logic [31:0]   root,
   input  psdc_side_type side_in,
   input  psdc_cfg_type  cfg,
   output logic          valid_out,
   output logic [15:0]   prog_q,
   output logic [15:0]   slow_q,
   output psdc_tail_type tail_out
);

   typedef struct packed {
      logic [31:0]   p_r;
      logic [31:0]   p_d;
      logic [15:0]   p_q;
      logic [30:0]   s_r;
      logic [30:0]   s_d;
      logic [15:0]   s_low;
      logic [15:0]   s_q;
      psdc_tail_type tail;
   } psdc_dstage_type;

   // setup stage
   logic          v5_ff;
   psdc_tail_type tail5_ff, tail5_in;
   logic [31:0]   mulb_ff, mulb_in, pr0_ff, pr0_in, pd_ff, pd_in;
   logic [30:0]   sd_ff, sd_in;

   logic [32:0] trav;
   logic [33:0] rem;
   logic        s_done, s_full, s_slow;
   logic [14:0] mula;
   logic [46:0] numer;

   logic            valid_ff [DIV_STEPS+1];
   psdc_dstage_type ds_ff    [DIV_STEPS+1];
   psdc_dstage_type ds0_in;

   always_comb begin
      trav   = side_in.sq_ovf ? {1'b1, 32'd0} : {1'b0, root};
      rem    = {2'b00, side_in.target} - {1'b0, trav};
      s_done = $signed(rem) <= $signed({18'd0, DIST_TOL});
      s_full = trav >= {1'b0, side_in.target};
      s_slow = (cfg.slow_distance != 31'd0) && ($signed(rem) < $signed({3'b000, cfg.slow_distance}));

      tail5_in.is_turn      = side_in.is_turn;
      tail5_in.ang_straight = side_in.ang_straight;
      if (side_in.is_turn) begin
         tail5_in.done = side_in.t_done;
         tail5_in.prog = side_in.t_prog;
         tail5_in.slow = side_in.t_slow;
         tail5_in.neg  = side_in.t_rem_neg;
         mulb_in = {16'd0, side_in.t_arem};
         pr0_in  = {16'd0, side_in.t_ad};
         pd_in   = {16'd0, side_in.t_at};
         sd_in   = {16'd0, cfg.slow_angle};
      end else begin
         tail5_in.done = s_done;
         tail5_in.prog = s_full ? PROG_FULL : PROG_DIV;
         tail5_in.slow = s_slow;
         tail5_in.neg  = side_in.dist_neg;
         mulb_in = rem[31:0];
         pr0_in  = trav[31:0];
         pd_in   = side_in.target;
         sd_in   = cfg.slow_distance;
      end
   end

   always_comb begin
      mula  = tail5_ff.is_turn ? cfg.turn_rate_nominal : cfg.travel_speed;
      numer = mula * mulb_ff;
      ds0_in.p_r   = pr0_ff;
      ds0_in.p_d   = pd_ff;
      ds0_in.p_q   = '0;
      ds0_in.s_r   = numer[46:16];
      ds0_in.s_d   = sd_ff;
      ds0_in.s_low = numer[15:0];
      ds0_in.s_q   = '0;
      ds0_in.tail  = tail5_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff       <= 1'b0;
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         v5_ff       <= valid_in;
         valid_ff[0] <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tail5_ff <= tail5_in;
         mulb_ff  <= mulb_in;
         pr0_ff   <= pr0_in;
         pd_ff    <= pd_in;
         sd_ff    <= sd_in;
         ds_ff[0] <= ds0_in;
      end
   end

   for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
      psdc_dstage_type cur, nxt;
      logic [32:0] pr2, pdiff;
      logic [31:0] sr2, sdiff;
      logic        pge, sge;

      assign cur = ds_ff[k-1];

      always_comb begin
         pr2   = {cur.p_r, 1'b0};
         pdiff = pr2 - {1'b0, cur.p_d};
         pge   = pr2 >= {1'b0, cur.p_d};
         sr2   = {cur.s_r, cur.s_low[15]};
         sdiff = sr2 - {1'b0, cur.s_d};
         sge   = sr2 >= {1'b0, cur.s_d};
         nxt       = cur;
         nxt.p_r   = pge ? pdiff[31:0] : pr2[31:0];
         nxt.p_q   = {cur.p_q[14:0], pge};
         nxt.s_r   = sge ? sdiff[30:0] : sr2[30:0];
         nxt.s_low = {cur.s_low[14:0], 1'b0};
         nxt.s_q   = {cur.s_q[14:0], sge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ds_ff[k] <= nxt;
         end
      end
   end

   assign valid_out = valid_ff[DIV_STEPS];
   assign prog_q    = ds_ff[DIV_STEPS].p_q;
   assign slow_q    = ds_ff[DIV_STEPS].s_q;
   assign tail_out  = ds_ff[DIV_STEPS].tail;

endmodule

// ===== rtl/core/path_segment_drive_command.sv =====
// ----------------------------------------------------------------------------
// path_segment_drive_command
// Drive command for one path segment: progress, completion, speed and
// steering for straight and turn segments.
// ----------------------------------------------------------------------------
//   port group   direction   contents
//   req_*        in          segment and poses, valid/ready
//   rsp_*        out         drive command word, valid/ready
//   csr_*        in          register write, no wait
//
// One word enters per cycle unless the output stalls; its path runs through
// the 32-stage square root and the 16-step progress and slowdown dividers.
// Synchronous reset clears the valid bits of every stage and the output.
// A stalled output freezes all stages at once; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module path_segment_drive_command
   import psdc_pkg::*;
#(
   parameter logic [15:0] DIST_TOL   = DIST_TOLERANCE,
   parameter logic [15:0] YAW_TOL    = YAW_TOLERANCE,
   parameter logic [15:0] DEADZONE   = YAW_DEADZONE,
   parameter logic [14:0] RATE_FLOOR = TURN_RATE_FLOOR
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  psdc_req_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output psdc_rsp_type           rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   psdc_cfg_type  cfg_ff;
   logic          en;
   logic          fr_valid, sq_valid, dv_valid;
   logic [63:0]   sq_val;
   logic [31:0]   root;
   psdc_side_type fr_side, sq_side;
   logic [15:0]   prog_q, slow_q;
   psdc_tail_type tail;
   logic          rsp_valid_ff;
   psdc_rsp_type  rsp_data_ff, rsp_data_in;
   logic [14:0]   speed, rate;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.travel_speed       <= RST_TRAVEL_SPEED;
         cfg_ff.slow_distance      <= RST_SLOW_DISTANCE;
         cfg_ff.creep_floor        <= RST_CREEP_FLOOR;
         cfg_ff.heading_gain       <= RST_HEADING_GAIN;
         cfg_ff.max_angular_rate   <= RST_MAX_ANGULAR_RATE;
         cfg_ff.turn_rate_nominal  <= RST_TURN_RATE_NOMINAL;
         cfg_ff.slow_angle         <= RST_SLOW_ANGLE;
         cfg_ff.turn_forward_speed <= RST_TURN_FORWARD_SPEED;
      end else if (csr_write) begin
         unique case (psdc_reg_type'(csr_index))
            REG_TRAVEL_SPEED:       cfg_ff.travel_speed       <= csr_wdata[14:0];
            REG_SLOW_DISTANCE:      cfg_ff.slow_distance      <= csr_wdata[30:0];
            REG_CREEP_FLOOR:        cfg_ff.creep_floor        <= csr_wdata[14:0];
            REG_HEADING_GAIN:       cfg_ff.heading_gain       <= csr_wdata[15:0];
            REG_MAX_ANGULAR_RATE:   cfg_ff.max_angular_rate   <= csr_wdata[14:0];
            REG_TURN_RATE_NOMINAL:  cfg_ff.turn_rate_nominal  <= csr_wdata[14:0];
            REG_SLOW_ANGLE:         cfg_ff.slow_angle         <= csr_wdata[14:0];
            REG_TURN_FORWARD_SPEED: cfg_ff.turn_forward_speed <= csr_wdata[15:0];
         endcase
      end
   end

   psdc_front #(
      .YAW_TOL  (YAW_TOL),
      .DEADZONE (DEADZONE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (req_valid && req_ready),
      .req       (req_data),
      .cfg       (cfg_ff),
      .valid_out (fr_valid),
      .sq_val    (sq_val),
      .side_out  (fr_side)
   );

   psdc_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (fr_valid),
      .val_in    (sq_val),
      .side_in   (fr_side),
      .valid_out (sq_valid),
      .root      (root),
      .side_out  (sq_side)
   );

   psdc_div_pipe #(
      .DIST_TOL (DIST_TOL)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (sq_valid),
      .root      (root),
      .side_in   (sq_side),
      .cfg       (cfg_ff),
      .valid_out (dv_valid),
      .prog_q    (prog_q),
      .slow_q    (slow_q),
      .tail_out  (tail)
   );

   always_comb begin
      speed = cfg_ff.travel_speed;
      if (tail.slow) begin
         speed = (slow_q > {1'b0, cfg_ff.creep_floor}) ? slow_q[14:0]
                                                        : cfg_ff.creep_floor;
      end
      rate = cfg_ff.turn_rate_nominal;
      if (tail.slow) begin
         rate = (slow_q > {1'b0, RATE_FLOOR}) ? slow_q[14:0] : RATE_FLOOR;
      end

      rsp_data_in.segment_done = tail.done;
      unique case (tail.prog)
         PROG_FULL: rsp_data_in.progress_fraction = 17'h10000;
         PROG_ZERO: rsp_data_in.progress_fraction = 17'd0;
         PROG_DIV:  rsp_data_in.progress_fraction = {1'b0, prog_q};
         default:   rsp_data_in.progress_fraction = 17'd0;
      endcase

      if (tail.done) begin
         rsp_data_in.linear_command  = '0;
         rsp_data_in.angular_command = '0;
      end else if (tail.is_turn) begin
         rsp_data_in.linear_command  = cfg_ff.turn_forward_speed;
         rsp_data_in.angular_command = tail.neg ? (16'sd0 - $signed({1'b0, rate}))
                                                : $signed({1'b0, rate});
      end else begin
         rsp_data_in.linear_command  = tail.neg ? (16'sd0 - $signed({1'b0, speed}))
                                                : $signed({1'b0, speed});
         rsp_data_in.angular_command = $signed(tail.ang_straight);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a finished segment drives nothing
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.segment_done |->
         rsp_data.linear_command == 16'sd0 && rsp_data.angular_command == 16'sd0)
      else $error("done word carries a nonzero command");

   a_prog_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.progress_fraction <= 17'h10000)
      else $error("progress above full scale");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output word valid right after reset");

endmodule

// ===== tb/path_segment_drive_command_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_segment_drive_command_tb
// Drives directed and random-pose straight and turn segments through the
// drive command pipeline, predicts each command word in the bench and
// checks every output field in order, across several register settings.
// ----------------------------------------------------------------------------
module path_segment_drive_command_tb;
   import psdc_pkg::*;

   localparam int LATENCY   = 55;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 550;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   psdc_req_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   psdc_rsp_type           rsp_data;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   path_segment_drive_command dut (.*);

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   psdc_cfg_type cfg;
   psdc_rsp_type cmd_queue[$];
   int           n_errors;
   int           n_sent;
   int           n_checked;
   int           n_done_seen;
   int           n_turn_sent;
   int           idle_cycles;
   bit           hold_long;
   bit           stim_over;

   // 64-bit integer square root, floor
   function automatic longint unsigned isqrt(input longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic psdc_rsp_type drive_command(input psdc_req_type w);
      psdc_rsp_type    c;
      longint          seg_len, dx, dy, rem, e, tgt, dlt;
      longint unsigned ax, ay, sx, sy, trav, target, prog, ae, mag, speed, arem;
      longint unsigned ad, at, rate;
      logic [15:0]     wr;
      c = '0;
      if (!w.segment_is_turn) begin
         seg_len = longint'(w.segment_distance);
         dx = longint'(w.current_x) - longint'(w.start_x);
         dy = longint'(w.current_y) - longint'(w.start_y);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         sx = ax * ax;
         sy = ay * ay;
         trav = (sx + sy < sx) ? (64'd1 << 32) : isqrt(sx + sy);
         target = seg_len < 0 ? -seg_len : seg_len;
         rem = longint'(target) - longint'(trav);
         if (target > 0) begin
            prog = (trav << 16) / target;
            if (prog > 65536) prog = 65536;
         end else begin
            prog = 65536;
         end
         c.progress_fraction = prog[16:0];
         c.segment_done = rem <= longint'(DIST_TOLERANCE);
         if (!c.segment_done) begin
            wr = w.start_yaw - w.current_yaw;
            e = longint'($signed(wr));
            ae = e < 0 ? -e : e;
            ae = ae <= YAW_DEADZONE ? 0 : ae - YAW_DEADZONE;
            mag = (longint'(cfg.heading_gain) * ae * PI_Q16 + (64'd1 << 26)) >> 27;
            if (mag > cfg.max_angular_rate) mag = cfg.max_angular_rate;
            c.angular_command = e < 0 ? -mag[15:0] : mag[15:0];
            speed = cfg.travel_speed;
            if (cfg.slow_distance > 0 && rem < longint'(cfg.slow_distance)) begin
               speed = longint'(cfg.travel_speed) * rem / cfg.slow_distance;
               if (speed < cfg.creep_floor) speed = cfg.creep_floor;
            end
            c.linear_command = seg_len >= 0 ? speed[15:0] : -speed[15:0];
         end
      end else begin
         tgt = longint'(w.segment_turn_angle);
         wr = w.current_yaw - w.start_yaw;
         dlt = longint'($signed(wr));
         rem = tgt - dlt;
         arem = rem < 0 ? -rem : rem;
         if (tgt == 0) begin
            prog = 65536;
         end else if ((dlt < 0) != (tgt < 0) && dlt != 0) begin
            prog = 0;
         end else begin
            ad = dlt < 0 ? -dlt : dlt;
            at = tgt < 0 ? -tgt : tgt;
            prog = (ad << 16) / at;
            if (prog > 65536) prog = 65536;
         end
         c.progress_fraction = prog[16:0];
         c.segment_done = arem <= YAW_TOLERANCE;
         if (!c.segment_done) begin
            rate = cfg.turn_rate_nominal;
            if (cfg.slow_angle > 0 && arem < cfg.slow_angle) begin
               rate = longint'(cfg.turn_rate_nominal) * arem / cfg.slow_angle;
               if (rate < TURN_RATE_FLOOR) rate = TURN_RATE_FLOOR;
            end
            c.angular_command = rem >= 0 ? rate[15:0] : -rate[15:0];
            c.linear_command = cfg.turn_forward_speed;
         end
      end
      return c;
   endfunction

   // the caller drops the write enable after its last write
   task automatic write_reg(input psdc_reg_type idx, input logic [30:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_TRAVEL_SPEED:       cfg.travel_speed       = val[14:0];
         REG_SLOW_DISTANCE:      cfg.slow_distance      = val[30:0];
         REG_CREEP_FLOOR:        cfg.creep_floor        = val[14:0];
         REG_HEADING_GAIN:       cfg.heading_gain       = val[15:0];
         REG_MAX_ANGULAR_RATE:   cfg.max_angular_rate   = val[14:0];
         REG_TURN_RATE_NOMINAL:  cfg.turn_rate_nominal  = val[14:0];
         REG_SLOW_ANGLE:         cfg.slow_angle         = val[14:0];
         REG_TURN_FORWARD_SPEED: cfg.turn_forward_speed = val[15:0];
         default: ;
      endcase
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // send one word; the command queue is filled at acceptance
   task automatic send_word(input psdc_req_type w, input bit use_gaps);
      int g;
      g = use_gaps ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cmd_queue.push_back(drive_command(w));
      n_sent++;
      if (w.segment_is_turn) n_turn_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (cmd_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic psdc_req_type random_word();
      psdc_req_type w;
      logic [287:0] raw;
      logic signed [31:0] span;
      int mode;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
      w = raw[$bits(psdc_req_type)-1:0];
      mode = $urandom_range(0, 9);
      if (mode < 7) begin
         // keep the pose near the segment so every phase of it gets exercised
         span = $signed($urandom_range(0, 400000));
         w.segment_distance = $urandom_range(0, 1) ? span : -span;
         w.current_x = w.start_x + $signed($urandom_range(0, 450000)) - 200000;
         w.current_y = w.start_y + $signed($urandom_range(0, 60000)) - 30000;
         w.current_yaw = w.start_yaw + 16'($urandom_range(0, 4000)) - 16'd2000;
         w.segment_turn_angle = 16'($urandom_range(0, 40000)) - 16'd20000;
         if (w.segment_is_turn)
            w.current_yaw = w.start_yaw + 16'($urandom_range(0, 45000)) - 16'd22000;
      end
      return w;
   endfunction

   // directed rows: word plus a typed expectation where it is obvious
   typedef struct {
      psdc_req_type w;
      bit           has_exp;
      psdc_rsp_type e;
   } row_type;

   row_type rows[$];

   function automatic psdc_req_type mk(input bit turn, input logic [31:0] seg_len,
                                       input logic [15:0] ang,
                                       input logic [31:0] sx, input logic [31:0] sy,
                                       input logic [15:0] syaw,
                                       input logic [31:0] cx, input logic [31:0] cy,
                                       input logic [15:0] cyaw);
      psdc_req_type w;
      w = '{turn, seg_len, ang, sx, sy, syaw, cx, cy, cyaw};
      return w;
   endfunction

   task automatic add_row(input psdc_req_type w, input bit has_exp,
                          input psdc_rsp_type e);
      row_type r;
      r.w = w;
      r.has_exp = has_exp;
      r.e = e;
      rows.push_back(r);
   endtask

   // output side
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cmd_queue.size() == 0) begin
            $error("command word with nothing expected");
            n_errors++;
         end else begin
            psdc_rsp_type x;
            x = cmd_queue.pop_front();
            n_checked++;
            if (rsp_data.segment_done) n_done_seen++;
            if (rsp_data.linear_command !== x.linear_command) begin
               $error("linear_command exp %0d got %0d", x.linear_command,
                      rsp_data.linear_command);
               n_errors++;
            end
            if (rsp_data.angular_command !== x.angular_command) begin
               $error("angular_command exp %0d got %0d", x.angular_command,
                      rsp_data.angular_command);
               n_errors++;
            end
            if (rsp_data.progress_fraction !== x.progress_fraction) begin
               $error("progress_fraction exp %0d got %0d", x.progress_fraction,
                      rsp_data.progress_fraction);
               n_errors++;
            end
            if (rsp_data.segment_done !== x.segment_done) begin
               $error("segment_done exp %0d got %0d", x.segment_done,
                      rsp_data.segment_done);
               n_errors++;
            end
         end
      end
   end

   // receiver stalls; one long hold-off on request
   initial begin
      int g, k;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_ready <= 1'b0;
            for (k = 0; k < 300; k++) @(posedge clock);
            hold_long = 1'b0;
         end
         g = gap_len();
         if (g > 0 && $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_over)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
         $display("path_segment_drive_command: mismatch");
         $finish;
      end
   end

   initial begin
      psdc_rsp_type e;
      int ph, k;
      n_errors = 0; n_sent = 0; n_checked = 0; n_done_seen = 0; n_turn_sent = 0;
      idle_cycles = 0; hold_long = 1'b0; stim_over = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg = '{RST_TRAVEL_SPEED, RST_SLOW_DISTANCE, RST_CREEP_FLOOR,
              RST_HEADING_GAIN, RST_MAX_ANGULAR_RATE, RST_TURN_RATE_NOMINAL,
              RST_SLOW_ANGLE, RST_TURN_FORWARD_SPEED};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // at start: zero length straight, standing still -> full and done
      add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{16'sd0, 16'sd0, 17'd65536, 1'b1});
      // zero turn target, no rotation -> full and done
      add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{16'sd0, 16'sd0, 17'd65536, 1'b1});
      // long straight at start, aligned: cruise, no steering
      add_row(mk(0, 32'sd655360, 0, 0, 0, 0, 0, 0, 0), 1,
              '{16'sd2048, 16'sd0, 17'd0, 1'b0});
      // backward straight
      add_row(mk(0, -32'sd655360, 0, 0, 0, 0, 0, 0, 0), 1,
              '{-16'sd2048, 16'sd0, 17'd0, 1'b0});
      // huge displacement saturates
      add_row(mk(0, 32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0,
                 32'h7fffffff, 32'h7fffffff, 0), 1, '{16'sd0, 16'sd0, 17'd65536, 1'b1});
      add_row(mk(0, 32'h80000000, 0, 32'h7fffffff, 0, 16'h7fff, 32'h80000000, 0,
                 16'h8000), 0, e);
      // yaw difference of pi, heading inside and outside the deadband
      add_row(mk(0, 32'sd655360, 0, 0, 0, 16'h8000, 0, 0, 0), 0, e);
      add_row(mk(0, 32'sd655360, 0, 0, 0, 16'sd182, 0, 0, 0), 0, e);
      add_row(mk(0, 32'sd655360, 0, 0, 0, 16'sd183, 0, 0, 0), 0, e);
      add_row(mk(0, 32'sd655360, 0, 0, 0, -16'sd3000, 0, 0, 0), 0, e);
      // inside the slowdown zone, near the creep floor, at the tolerance
      add_row(mk(0, 32'sd100000, 0, 0, 0, 0, 32'sd90000, 0, 0), 0, e);
      add_row(mk(0, 32'sd100000, 0, 0, 0, 0, 32'sd98000, 0, 0), 0, e);
      add_row(mk(0, 32'sd100000, 0, 0, 0, 0, 32'sd98689, 0, 0), 0, e);
      add_row(mk(0, 32'sd100000, 0, 0, 0, 0, 32'sd98688, 0, 0), 0, e);
      // turns: start, halfway, overshoot, wrong way, pi, tolerance edges
      add_row(mk(1, 0, 16'sd8192, 0, 0, 0, 0, 0, 0), 1,
              '{16'sd1229, 16'sd4096, 17'd0, 1'b0});
      add_row(mk(1, 0, -16'sd8192, 0, 0, 16'sd100, 0, 0, -16'sd4000), 0, e);
      add_row(mk(1, 0, 16'sd8192, 0, 0, 0, 0, 0, 16'sd9000), 0, e);
      add_row(mk(1, 0, 16'sd8192, 0, 0, 0, 0, 0, -16'sd500), 0, e);
      add_row(mk(1, 0, 16'h7fff, 0, 0, 16'h4000, 0, 0, 16'hc000), 0, e);
      add_row(mk(1, 0, 16'h8000, 0, 0, 16'h7fff, 0, 0, 16'h8000), 0, e);
      add_row(mk(1, 0, 16'sd1000, 0, 0, 0, 0, 0, 16'sd636), 0, e);
      add_row(mk(1, 0, 16'sd1000, 0, 0, 0, 0, 0, 16'sd635), 0, e);
      add_row(mk(1, 0, 16'sd1000, 0, 0, 0, 0, 0, 16'sd300), 0, e);

      foreach (rows[i]) begin
         send_word(rows[i].w, 1'b0);
         // swap in the typed expectation where one was given
         if (rows[i].has_exp) cmd_queue[cmd_queue.size()-1] = rows[i].e;
      end
      drain();

      for (ph = 0; ph < 5; ph++) begin
         repeat (LATENCY) @(posedge clock);
         case (ph)
            0: begin
               // extremes high
               write_reg(REG_TRAVEL_SPEED, 31'h7fff);
               write_reg(REG_SLOW_DISTANCE, 31'h7fffffff);
               write_reg(REG_CREEP_FLOOR, 31'h7fff);
               write_reg(REG_HEADING_GAIN, 31'hffff);
               write_reg(REG_MAX_ANGULAR_RATE, 31'h7fff);
               write_reg(REG_TURN_RATE_NOMINAL, 31'h7fff);
               write_reg(REG_SLOW_ANGLE, 31'h7fff);
               write_reg(REG_TURN_FORWARD_SPEED, 31'h8000);
            end
            1: begin
               // extremes low: slowdown disabled
               write_reg(REG_TRAVEL_SPEED, 31'd0);
               write_reg(REG_SLOW_DISTANCE, 31'd0);
               write_reg(REG_CREEP_FLOOR, 31'd0);
               write_reg(REG_HEADING_GAIN, 31'd0);
               write_reg(REG_MAX_ANGULAR_RATE, 31'd0);
               write_reg(REG_TURN_RATE_NOMINAL, 31'd0);
               write_reg(REG_SLOW_ANGLE, 31'd0);
               write_reg(REG_TURN_FORWARD_SPEED, 31'h7fff);
            end
            default: begin
               write_reg(REG_TRAVEL_SPEED, 31'($urandom_range(0, 32767)));
               write_reg(REG_SLOW_DISTANCE, 31'($urandom_range(0, 600000)));
               write_reg(REG_CREEP_FLOOR, 31'($urandom_range(0, 32767)));
               write_reg(REG_HEADING_GAIN, 31'($urandom_range(0, 65535)));
               write_reg(REG_MAX_ANGULAR_RATE, 31'($urandom_range(0, 32767)));
               write_reg(REG_TURN_RATE_NOMINAL, 31'($urandom_range(0, 32767)));
               write_reg(REG_SLOW_ANGLE, 31'($urandom_range(0, 32767)));
               write_reg(REG_TURN_FORWARD_SPEED, 31'($urandom_range(0, 65535)));
            end
         endcase
         csr_write <= 1'b0;
         for (k = 0; k < N_RANDOM / 5; k++) begin
            if (ph == 2 && k == 10) hold_long = 1'b1;
            send_word(random_word(), k >= 60);
         end
         drain();
      end

      stim_over = 1'b1;
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d words (%0d turns), %0d checked, %0d done",
               n_sent, n_turn_sent, n_checked, n_done_seen);
      $display("five register settings including both extremes");
      if (n_errors == 0 && cmd_queue.size() == 0)
         $display("path_segment_drive_command: match");
      else
         $display("path_segment_drive_command: mismatch");
      $finish;
   end

endmodule
